@@ src/wjmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wjmc_pkg;

    localparam int HEIGHT_BITS  = 16;
    localparam int COST_BITS    = 32;
    localparam int LIMIT_BITS   = 5;
    localparam int MAX_JUMP_DEF = 16;
    localparam int LIMIT_RESET  = 1;

    typedef logic [HEIGHT_BITS-1:0] t_height;
    typedef logic [COST_BITS-1:0]   t_cost;
    typedef logic [LIMIT_BITS-1:0]  t_jump_limit;

    typedef struct packed {
        t_height height;
        logic    last_height;
    } t_in_item;

    typedef struct packed {
        t_cost min_cost;
        logic  is_last;
    } t_out_item;

endpackage

`default_nettype wire

@@ src/wjmc_best_cost.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wjmc_best_cost
    import wjmc_pkg::*;
#(
    parameter int MAX_JUMP = MAX_JUMP_DEF,
    parameter int CNT_W    = $clog2(MAX_JUMP + 1)
) (
    input  wire t_height     i_height,
    input  wire t_height     i_hist_h [MAX_JUMP],
    input  wire t_cost       i_hist_c [MAX_JUMP],
    input  wire [CNT_W-1:0]  i_seen,
    input  wire t_jump_limit i_jump_limit,
    output t_cost            o_best
);

    localparam int LIM_W  = (CNT_W > LIMIT_BITS) ? CNT_W : LIMIT_BITS;
    localparam int LEAVES = 1 << $clog2(MAX_JUMP);

    logic [LIM_W-1:0] lim_raw;
    logic [LIM_W-1:0] lim_eff;
    logic [LIM_W-1:0] seen_ext;
    t_cost            node [2*LEAVES-1];

    assign lim_raw  = LIM_W'(i_jump_limit);
    assign seen_ext = LIM_W'(i_seen);

    always_comb begin
        if (lim_raw == '0) begin
            lim_eff = LIM_W'(1);
        end else if (lim_raw > LIM_W'(MAX_JUMP)) begin
            lim_eff = LIM_W'(MAX_JUMP);
        end else begin
            lim_eff = lim_raw;
        end
    end

    // Each window entry forms one candidate; entries outside the reach or not yet
    // filled enter the tree as all ones so they never win.
    genvar gi;
    generate
        for (gi = 0; gi < LEAVES; gi++) begin : g_leaf
            if (gi < MAX_JUMP) begin : g_cand
                t_height                diff;
                logic [COST_BITS:0]     sum;
                logic                   ok;
                assign diff = (i_height >= i_hist_h[gi]) ? (i_height - i_hist_h[gi])
                                                         : (i_hist_h[gi] - i_height);
                assign sum  = {1'b0, i_hist_c[gi]} + (COST_BITS + 1)'(diff);
                assign ok   = (seen_ext > LIM_W'(gi)) && (lim_eff > LIM_W'(gi));
                assign node[LEAVES-1+gi] = !ok            ? '1 :
                                           sum[COST_BITS] ? '1 : sum[COST_BITS-1:0];
            end else begin : g_pad
                assign node[LEAVES-1+gi] = '1;
            end
        end
        for (gi = 0; gi < LEAVES - 1; gi++) begin : g_tree
            assign node[gi] = (node[2*gi+2] < node[2*gi+1]) ? node[2*gi+2] : node[2*gi+1];
        end
    endgenerate

    assign o_best = (i_seen == '0) ? '0 : node[0];

endmodule

`default_nettype wire

@@ src/windowed_jump_min_cost_dp_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_data   (t_in_item)
// out       output     o_out_valid / i_out_ready  o_out_data  (t_out_item)
// cfg       input      i_cfg_we (no wait)         i_cfg_data  (jump limit)
//
// One height is taken per cycle unless the output stalls.
// The path from the input register to the result register holds one absolute
// difference and saturating add per window entry and a min tree over MAX_JUMP.
// Reset clears the valid flags and the fill count and sets the jump limit to 1.
// A stalled output holds the result while one more height waits in the input register.

module windowed_jump_min_cost_dp_unit
    import wjmc_pkg::*;
#(
    parameter int MAX_JUMP = MAX_JUMP_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire t_in_item i_in_data,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output t_out_item   o_out_data,
    input  wire         i_cfg_we,
    input  wire t_jump_limit i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_JUMP + 1);

    logic             r_in_valid;
    t_in_item         r_in_item;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_height          r_hist_h [MAX_JUMP];
    t_cost            r_hist_c [MAX_JUMP];
    logic [CNT_W-1:0] r_seen;
    t_jump_limit      r_jump_limit;

    logic             advance;
    t_cost            best;
    logic [CNT_W-1:0] n_seen;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    wjmc_best_cost #(
        .MAX_JUMP (MAX_JUMP),
        .CNT_W    (CNT_W)
    ) u_best (
        .i_height     (r_in_item.height),
        .i_hist_h     (r_hist_h),
        .i_hist_c     (r_hist_c),
        .i_seen       (r_seen),
        .i_jump_limit (r_jump_limit),
        .o_best       (best)
    );

    always_comb begin
        if (r_in_item.last_height) begin
            n_seen = '0;
        end else if (r_seen < CNT_W'(MAX_JUMP)) begin
            n_seen = r_seen + CNT_W'(1);
        end else begin
            n_seen = r_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_seen       <= '0;
            r_jump_limit <= LIMIT_BITS'(LIMIT_RESET);
        end else begin
            if (i_cfg_we) begin
                r_jump_limit <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_seen      <= n_seen;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
        if (advance) begin
            r_out_item.min_cost <= best;
            r_out_item.is_last  <= r_in_item.last_height;
            for (int j = MAX_JUMP - 1; j > 0; j--) begin
                r_hist_h[j] <= r_hist_h[j-1];
                r_hist_c[j] <= r_hist_c[j-1];
            end
            r_hist_h[0] <= r_in_item.height;
            r_hist_c[0] <= best;
        end
    end

`ifndef SYNTHESIS
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= CNT_W'(MAX_JUMP))
        else $error("Fill count exceeds the window depth.");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_item.last_height |=> r_seen == '0)
        else $error("Window not cleared after the final position.");

    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_seen == '0 |=> o_out_valid && o_out_data.min_cost == '0)
        else $error("First position of a sequence has nonzero cost.");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_item))
        else $error("Waiting input item lost or changed.");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("Result register not loaded after a computation.");
`endif

endmodule

`default_nettype wire

@@ bench/tb_windowed_jump_min_cost_dp_unit.sv @@
`timescale 1ns / 1ps

module tb_windowed_jump_min_cost_dp_unit;
    import wjmc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_CAP  = 50;

    typedef enum logic {ROW_ITEM, ROW_LIMIT} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        int unsigned value;
        bit          last;
        bit          typed;
        int unsigned cost;
    } t_script_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we    = 1'b0;
    t_jump_limit i_cfg_data  = '0;

    t_height     win_height [MAX_JUMP_DEF];
    t_cost       win_cost [MAX_JUMP_DEF];
    int unsigned fill_count;
    t_jump_limit cur_limit;

    t_out_item   cost_queue [$];
    t_out_item   want;
    int unsigned fail_count    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    t_script_row script [25];

    windowed_jump_min_cost_dp_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic void clear_window();
        for (int j = 0; j < MAX_JUMP_DEF; j++) begin
            win_height[j] = '0;
            win_cost[j]   = '0;
        end
        fill_count = 0;
    endfunction

    function automatic t_cost advance_window(input t_in_item item);
        int unsigned       span;
        int unsigned       reach;
        t_height           diff;
        logic [COST_BITS:0] sum;
        t_cost             best;
        span = cur_limit;
        if (span < 1) span = 1;
        if (span > MAX_JUMP_DEF) span = MAX_JUMP_DEF;
        best = '0;
        if (fill_count > 0) begin
            reach = (fill_count < span) ? fill_count : span;
            best  = '1;
            for (int j = 0; j < reach; j++) begin
                diff = (item.height >= win_height[j]) ? item.height - win_height[j]
                                                      : win_height[j] - item.height;
                sum  = {1'b0, win_cost[j]} + diff;
                if (sum[COST_BITS]) sum = '1;
                if (sum[COST_BITS-1:0] < best) best = sum[COST_BITS-1:0];
            end
        end
        if (item.last_height) begin
            clear_window();
        end else begin
            for (int j = MAX_JUMP_DEF - 1; j > 0; j--) begin
                win_height[j] = win_height[j-1];
                win_cost[j]   = win_cost[j-1];
            end
            win_height[0] = item.height;
            win_cost[0]   = best;
            if (fill_count < MAX_JUMP_DEF) fill_count++;
        end
        return best;
    endfunction

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (cost_queue.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_CAP) begin
                    $error("unexpected transfer on the output: min_cost %0d, is_last %0d",
                           o_out_data.min_cost, o_out_data.is_last);
                end
            end else begin
                want = cost_queue.pop_front();
                if (o_out_data.min_cost !== want.min_cost) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP) begin
                        $error("min_cost mismatch: expected %0d, actual %0d",
                               want.min_cost, o_out_data.min_cost);
                    end
                end
                if (o_out_data.is_last !== want.is_last) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP) begin
                        $error("is_last mismatch: expected %0d, actual %0d",
                               want.is_last, o_out_data.is_last);
                    end
                end
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_height(input t_in_item item, input bit typed, input t_cost typed_cost);
        t_out_item entry;
        t_cost     guess;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        guess = advance_window(item);
        entry.min_cost = typed ? typed_cost : guess;
        entry.is_last  = item.last_height;
        cost_queue.push_back(entry);
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (cost_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_limit(input int unsigned value);
        hold_until_drained();
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= t_jump_limit'(value);
        @(posedge i_clk);
        cur_limit = t_jump_limit'(value);
        i_cfg_we  <= 1'b0;
    endtask

    task automatic run_sequences(input int unsigned quota);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        t_in_item    item;
        t_height     prev;
        sent = 0;
        prev = '0;
        while (sent < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) len = 1;
            else if (pick < 80) len = $urandom_range(2, 24);
            else len = $urandom_range(17, 60);
            for (int unsigned pos = 0; pos < len; pos++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) item.height = t_height'($urandom);
                else if (pick < 60) item.height = '0;
                else if (pick < 75) item.height = '1;
                else item.height = prev + t_height'($urandom_range(0, 16)) - t_height'(8);
                item.last_height = (pos == len - 1) || ($urandom_range(0, 99) < 3);
                send_height(item, 1'b0, '0);
                prev = item.height;
                sent++;
                if (sent == quota / 2) hold_until_drained();
            end
        end
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_in_item item;
        script = '{
            '{ROW_ITEM,  0,     1, 1, 0},
            '{ROW_ITEM,  65535, 0, 1, 0},
            '{ROW_ITEM,  0,     0, 1, 65535},
            '{ROW_ITEM,  65535, 0, 1, 131070},
            '{ROW_ITEM,  65535, 1, 1, 131070},
            '{ROW_ITEM,  1234,  0, 1, 0},
            '{ROW_ITEM,  1234,  1, 1, 0},
            '{ROW_LIMIT, 0,     0, 0, 0},
            '{ROW_ITEM,  100,   0, 1, 0},
            '{ROW_ITEM,  50,    0, 1, 50},
            '{ROW_ITEM,  150,   1, 1, 150},
            '{ROW_LIMIT, 31,    0, 0, 0},
            '{ROW_ITEM,  10,    0, 1, 0},
            '{ROW_ITEM,  20,    0, 1, 10},
            '{ROW_ITEM,  30,    0, 0, 0},
            '{ROW_ITEM,  10,    0, 0, 0},
            '{ROW_ITEM,  65535, 1, 0, 0},
            '{ROW_LIMIT, 16,    0, 0, 0},
            '{ROW_ITEM,  0,     0, 1, 0},
            '{ROW_ITEM,  65535, 0, 1, 65535},
            '{ROW_ITEM,  0,     1, 0, 0},
            '{ROW_LIMIT, 2,     0, 0, 0},
            '{ROW_ITEM,  7,     0, 1, 0},
            '{ROW_ITEM,  9,     0, 1, 2},
            '{ROW_ITEM,  7,     1, 0, 0}
        };
        clear_window();
        cur_limit = t_jump_limit'(LIMIT_RESET);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 63;
        foreach (script[r]) begin
            if (script[r].kind == ROW_LIMIT) begin
                set_limit(script[r].value);
            end else begin
                item.height      = t_height'(script[r].value);
                item.last_height = script[r].last;
                send_height(item, script[r].typed, t_cost'(script[r].cost));
            end
        end
        run_sequences(60);
        set_limit(16);
        run_sequences(110);
        set_limit(3);
        run_sequences(110);

        send_idle_pct = 63;
        recv_idle_pct = 36;
        set_limit(31);
        run_sequences(110);
        set_limit(0);
        run_sequences(110);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limit(7);
        run_sequences(110);
        set_limit(1);
        run_sequences(50);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (cost_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
